>>> rtl/core/evm_pkg.sv
package evm_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] prog_counter_out;
        logic        draw_flag;
        logic        sound_on;
        logic        waiting_key;
        logic        bad_opcode;
    } t_out_item;

    localparam logic [1:0] KIND_MEM_WR = 2'd0;
    localparam logic [1:0] KIND_EXEC   = 2'd1;
    localparam logic [1:0] KIND_PIX_RD = 2'd2;
    localparam logic [1:0] KIND_MEM_RD = 2'd3;

    localparam logic [11:0] PC_RESET = 12'h200;

    // micro-operations issued by the controller
    localparam logic [4:0] U_NOP      = 5'd0;
    localparam logic [4:0] U_CLR      = 5'd1;
    localparam logic [4:0] U_TAKE     = 5'd2;
    localparam logic [4:0] U_MEMWR_IN = 5'd3;
    localparam logic [4:0] U_MEMRD_IN = 5'd4;
    localparam logic [4:0] U_PIXRD    = 5'd5;
    localparam logic [4:0] U_FETCH_HI = 5'd6;
    localparam logic [4:0] U_FETCH_LO = 5'd7;
    localparam logic [4:0] U_RD_X     = 5'd8;
    localparam logic [4:0] U_RD_Y     = 5'd9;
    localparam logic [4:0] U_RD_0     = 5'd10;
    localparam logic [4:0] U_EXEC     = 5'd11;
    localparam logic [4:0] U_RET      = 5'd12;
    localparam logic [4:0] U_FCLR     = 5'd13;
    localparam logic [4:0] U_WR_VF    = 5'd14;
    localparam logic [4:0] U_DMRD     = 5'd15;
    localparam logic [4:0] U_DFRD     = 5'd16;
    localparam logic [4:0] U_DFWR     = 5'd17;
    localparam logic [4:0] U_BCD0     = 5'd18;
    localparam logic [4:0] U_BCD1     = 5'd19;
    localparam logic [4:0] U_BCD2     = 5'd20;
    localparam logic [4:0] U_STRD     = 5'd21;
    localparam logic [4:0] U_STWR     = 5'd22;
    localparam logic [4:0] U_LDRD     = 5'd23;
    localparam logic [4:0] U_LDWR     = 5'd24;
    localparam logic [4:0] U_DONE     = 5'd25;

    typedef struct packed {
        logic [4:0]  uop;
        logic [11:0] cnt;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] op;
    } t_dp_status;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] MISC_GDT  = 8'h07;
    localparam logic [7:0] MISC_WKEY = 8'h0A;
    localparam logic [7:0] MISC_SDT  = 8'h15;
    localparam logic [7:0] MISC_SST  = 8'h18;
    localparam logic [7:0] MISC_ADDI = 8'h1E;
    localparam logic [7:0] MISC_FONT = 8'h29;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_STR  = 8'h55;
    localparam logic [7:0] MISC_LDR  = 8'h65;

    // sequencing class of an instruction after its execute step
    localparam logic [2:0] C_PLAIN = 3'd0;
    localparam logic [2:0] C_CLS   = 3'd1;
    localparam logic [2:0] C_RET   = 3'd2;
    localparam logic [2:0] C_FLAG  = 3'd3;
    localparam logic [2:0] C_DRAW  = 3'd4;
    localparam logic [2:0] C_BCD   = 3'd5;
    localparam logic [2:0] C_STORE = 3'd6;
    localparam logic [2:0] C_LOAD  = 3'd7;

    localparam int FONT_BYTES = 80;

    localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] f_font(input logic [11:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a < 12'(FONT_BYTES)) begin
            v = FONT[a[6:0]];
        end
        return v;
    endfunction

    function automatic logic [2:0] f_class(input logic [15:0] op);
        logic [2:0] c;
        c = C_PLAIN;
        case (op[15:12])
            OP_SYS: begin
                if (op == OPC_CLS) begin
                    c = C_CLS;
                end else if (op == OPC_RET) begin
                    c = C_RET;
                end
            end
            OP_ALU: begin
                if (op[3:0] inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL}) begin
                    c = C_FLAG;
                end
            end
            OP_DRW: c = C_DRAW;
            OP_MISC: begin
                case (op[7:0])
                    MISC_ADDI: c = C_FLAG;
                    MISC_BCD:  c = C_BCD;
                    MISC_STR:  c = C_STORE;
                    MISC_LDR:  c = C_LOAD;
                    default:   c = C_PLAIN;
                endcase
            end
            default: c = C_PLAIN;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/eight_bit_vm_instruction_core.sv
// CHIP-8 instruction core.
// Input channel (i_in_valid / o_in_ready) carries one transaction per item:
// write a memory byte, execute one instruction, read a display pixel or read
// a memory byte. Output channel (o_out_valid / i_out_ready) returns exactly
// one result transaction per input transaction, in order.
// Item steps: a memory or pixel access does its access, then loads its result;
// an instruction fetches, reads its registers and executes, then runs its own
// steps: a clear of every frame row for a screen clear, a sprite byte read,
// row read and row write per sprite row plus a VF write for a draw, the BCD
// digit writes, a read and a write per register for block store/load, a VF
// write for flag-setting ALU ops and I additions, a stack step for returns.
// One memory port and one frame-row port set these steps; one item at a time.
// The next item is accepted once the current one has finished its steps, even
// while the previous result still waits; if the receiver stalls, the core
// holds the finished item until the output register frees.
// After reset the core walks every memory address, clearing memory, display,
// registers and stack and preloading the font; o_in_ready stays low meanwhile.
// i_cfg_we/i_cfg_data load the start address and the program counter.
module eight_bit_vm_instruction_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  evm_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output evm_pkg::t_out_item   o_out_item
);
    import evm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    evm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    evm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_item     (o_out_item)
    );

endmodule

>>> rtl/core/evm_ctrl.sv
module evm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  evm_pkg::t_dp_status  i_status,
    output evm_pkg::t_ctrl_cmd   o_cmd
);
    import evm_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_F1   = 5'd4;
    localparam logic [4:0] S_F2   = 5'd5;
    localparam logic [4:0] S_F3   = 5'd6;
    localparam logic [4:0] S_F4   = 5'd7;
    localparam logic [4:0] S_EX   = 5'd8;
    localparam logic [4:0] S_RET  = 5'd9;
    localparam logic [4:0] S_FCLR = 5'd10;
    localparam logic [4:0] S_VF   = 5'd11;
    localparam logic [4:0] S_D0   = 5'd12;
    localparam logic [4:0] S_D1   = 5'd13;
    localparam logic [4:0] S_D2   = 5'd14;
    localparam logic [4:0] S_B0   = 5'd15;
    localparam logic [4:0] S_B1   = 5'd16;
    localparam logic [4:0] S_B2   = 5'd17;
    localparam logic [4:0] S_S0   = 5'd18;
    localparam logic [4:0] S_S1   = 5'd19;
    localparam logic [4:0] S_L0   = 5'd20;
    localparam logic [4:0] S_L1   = 5'd21;
    localparam logic [4:0] S_FIN  = 5'd22;

    logic [4:0]  r_state, n_state;
    logic [11:0] r_cnt, n_cnt;
    logic        r_ovalid, n_ovalid;
    logic [4:0]  uop;
    logic [3:0]  op_x, op_n;
    logic        slot_free;

    assign op_x = i_status.op[11:8];
    assign op_n = i_status.op[3:0];
    assign slot_free = !r_ovalid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd.uop   = uop;
    assign o_cmd.cnt   = r_cnt;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        uop      = U_NOP;
        case (r_state)
            S_CLR: begin
                uop = U_CLR;
                n_cnt = r_cnt + 12'd1;
                if (r_cnt == 12'hFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    uop = U_TAKE;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                case (i_status.kind)
                    KIND_MEM_WR: begin
                        uop = U_MEMWR_IN;
                        n_state = S_FIN;
                    end
                    KIND_PIX_RD: begin
                        uop = U_PIXRD;
                        n_state = S_FIN;
                    end
                    KIND_MEM_RD: begin
                        uop = U_MEMRD_IN;
                        n_state = S_FIN;
                    end
                    default: begin
                        uop = U_FETCH_HI;
                        n_state = S_F1;
                    end
                endcase
            end
            S_F1: begin
                uop = U_FETCH_LO;
                n_state = S_F2;
            end
            S_F2: begin
                uop = U_RD_X;
                n_state = S_F3;
            end
            S_F3: begin
                uop = U_RD_Y;
                n_state = S_F4;
            end
            S_F4: begin
                uop = U_RD_0;
                n_state = S_EX;
            end
            S_EX: begin
                uop = U_EXEC;
                n_cnt = 12'd0;
                case (f_class(i_status.op))
                    C_CLS:   n_state = S_FCLR;
                    C_RET:   n_state = S_RET;
                    C_FLAG:  n_state = S_VF;
                    C_DRAW:  n_state = (op_n == 4'd0) ? S_VF : S_D0;
                    C_BCD:   n_state = S_B0;
                    C_STORE: n_state = S_S0;
                    C_LOAD:  n_state = S_L0;
                    default: n_state = S_FIN;
                endcase
            end
            S_RET: begin
                uop = U_RET;
                n_state = S_FIN;
            end
            S_FCLR: begin
                uop = U_FCLR;
                n_cnt = r_cnt + 12'd1;
                if (r_cnt[4:0] == 5'd31) begin
                    n_state = S_FIN;
                end
            end
            S_VF: begin
                uop = U_WR_VF;
                n_state = S_FIN;
            end
            S_D0: begin
                uop = U_DMRD;
                n_state = S_D1;
            end
            S_D1: begin
                uop = U_DFRD;
                n_state = S_D2;
            end
            S_D2: begin
                uop = U_DFWR;
                n_cnt = r_cnt + 12'd1;
                n_state = (r_cnt[3:0] == op_n - 4'd1) ? S_VF : S_D0;
            end
            S_B0: begin
                uop = U_BCD0;
                n_state = S_B1;
            end
            S_B1: begin
                uop = U_BCD1;
                n_state = S_B2;
            end
            S_B2: begin
                uop = U_BCD2;
                n_state = S_FIN;
            end
            S_S0: begin
                uop = U_STRD;
                n_state = S_S1;
            end
            S_S1: begin
                uop = U_STWR;
                n_cnt = r_cnt + 12'd1;
                n_state = (r_cnt[3:0] == op_x) ? S_FIN : S_S0;
            end
            S_L0: begin
                uop = U_LDRD;
                n_state = S_L1;
            end
            S_L1: begin
                uop = U_LDWR;
                n_cnt = r_cnt + 12'd1;
                n_state = (r_cnt[3:0] == op_x) ? S_FIN : S_L0;
            end
            S_FIN: begin
                if (slot_free) begin
                    uop = U_DONE;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= 12'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

>>> rtl/core/evm_dp.sv
module evm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_data,
    input  evm_pkg::t_in_item    i_item,
    input  evm_pkg::t_ctrl_cmd   i_cmd,
    output evm_pkg::t_dp_status  o_status,
    output evm_pkg::t_out_item   o_item
);
    import evm_pkg::*;

    logic [7:0]  mem [0:4095];
    logic [7:0]  rf [0:15];
    logic [11:0] stk [0:15];
    logic [63:0] fb [0:31];

    logic [7:0]  r_mem_q;
    logic [7:0]  r_rf_q;
    logic [11:0] r_stk_q;
    logic [63:0] r_fb_q;

    t_in_item    r_item, n_item;
    t_out_item   r_out, n_out;
    logic [7:0]  r_hi, n_hi, r_lo, n_lo, r_vx, n_vx, r_vy, n_vy;
    logic [11:0] r_pc, n_pc, r_start_pc, n_start_pc, r_i, n_i;
    logic [3:0]  r_sp, n_sp;
    logic [7:0]  r_dt, n_dt, r_st, n_st;
    logic        r_flag, n_flag, r_draw, n_draw, r_wait, n_wait, r_bad, n_bad;
    logic [7:0]  r_sprite, n_sprite;
    logic [6:0]  r_tmp, n_tmp;

    logic        mem_we, mem_re, rf_we, rf_re, stk_we, stk_re, fb_we, fb_re;
    logic [11:0] mem_a, stk_wd;
    logic [7:0]  mem_wd, rf_wd;
    logic [3:0]  rf_wa, rf_ra, stk_a;
    logic [4:0]  fb_a;
    logic [63:0] fb_wd;

    logic [3:0]  op_x, op_n, cnt4, key_idx;
    logic [7:0]  nn;
    logic [11:0] nnn, pc2, pc4, i_cnt;
    logic [8:0]  sum9;
    logic [12:0] sum13;
    logic [7:0]  sprite_rev;
    logic [127:0] mask_w;
    logic [63:0] mask;
    logic [4:0]  draw_row;
    logic [1:0]  hund;
    logic [6:0]  rem100, ones;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic        key_hit;

    assign o_status.kind = r_item.kind;
    assign o_status.op   = {r_hi, r_lo};
    assign o_item        = r_out;

    assign op_x  = r_hi[3:0];
    assign op_n  = r_lo[3:0];
    assign nn    = r_lo;
    assign nnn   = {r_hi[3:0], r_lo};
    assign cnt4  = i_cmd.cnt[3:0];
    assign pc2   = r_pc + 12'd2;
    assign pc4   = r_pc + 12'd4;
    assign i_cnt = r_i + {8'd0, cnt4};
    assign sum9  = {1'b0, r_vx} + {1'b0, r_vy};
    assign sum13 = {1'b0, r_i} + {5'd0, r_vx};
    assign key_hit = r_item.keys_down[r_vx[3:0]];

    assign draw_row = r_vy[4:0] + {1'b0, cnt4};
    assign mask_w   = {64'd0, 56'd0, sprite_rev} << r_vx[5:0];
    assign mask     = mask_w[63:0] | mask_w[127:64];

    assign hund   = (r_vx >= 8'd200) ? 2'd2 : ((r_vx >= 8'd100) ? 2'd1 : 2'd0);
    assign rem100 = 7'(r_vx - ((r_vx >= 8'd200) ? 8'd200 : ((r_vx >= 8'd100) ? 8'd100 : 8'd0)));
    assign tens_prod = {8'd0, r_tmp} * 15'd205;
    assign tens   = tens_prod[14:11];
    assign ones   = r_tmp - ({tens, 3'b000} + {2'b00, tens, 1'b0});

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            sprite_rev[b] = r_sprite[7-b];
        end
    end

    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_item.keys_down[k]) begin
                key_idx = 4'(k);
            end
        end
    end

    always_comb begin
        n_item = r_item;
        n_out = r_out;
        n_hi = r_hi;
        n_lo = r_lo;
        n_vx = r_vx;
        n_vy = r_vy;
        n_pc = r_pc;
        n_start_pc = r_start_pc;
        n_i = r_i;
        n_sp = r_sp;
        n_dt = r_dt;
        n_st = r_st;
        n_flag = r_flag;
        n_draw = r_draw;
        n_wait = r_wait;
        n_bad = r_bad;
        n_sprite = r_sprite;
        n_tmp = r_tmp;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_a = r_item.address;
        mem_wd = r_item.data;
        rf_we = 1'b0;
        rf_re = 1'b0;
        rf_wa = op_x;
        rf_ra = op_x;
        rf_wd = 8'd0;
        stk_we = 1'b0;
        stk_re = 1'b0;
        stk_a = r_sp;
        stk_wd = 12'd0;
        fb_we = 1'b0;
        fb_re = 1'b0;
        fb_a = draw_row;
        fb_wd = 64'd0;
        case (i_cmd.uop)
            U_CLR: begin
                mem_we = 1'b1;
                mem_a = i_cmd.cnt;
                mem_wd = f_font(i_cmd.cnt);
                rf_we = 1'b1;
                rf_wa = cnt4;
                stk_we = 1'b1;
                stk_a = cnt4;
                fb_we = 1'b1;
                fb_a = i_cmd.cnt[4:0];
            end
            U_TAKE: begin
                n_item = i_item;
                n_draw = 1'b0;
                n_wait = 1'b0;
                n_bad = 1'b0;
            end
            U_MEMWR_IN: mem_we = 1'b1;
            U_MEMRD_IN: mem_re = 1'b1;
            U_PIXRD: begin
                fb_re = 1'b1;
                fb_a = r_item.address[10:6];
            end
            U_FETCH_HI: begin
                mem_re = 1'b1;
                mem_a = r_pc;
            end
            U_FETCH_LO: begin
                mem_re = 1'b1;
                mem_a = r_pc + 12'd1;
                n_hi = r_mem_q;
            end
            U_RD_X: begin
                n_lo = r_mem_q;
                rf_re = 1'b1;
                rf_ra = r_hi[3:0];
            end
            U_RD_Y: begin
                n_vx = r_rf_q;
                rf_re = 1'b1;
                rf_ra = r_lo[7:4];
            end
            U_RD_0: begin
                n_vy = r_rf_q;
                rf_re = 1'b1;
                rf_ra = 4'd0;
            end
            U_EXEC: begin
                n_pc = pc2;
                case (r_hi[7:4])
                    OP_SYS: begin
                        if ({r_hi, r_lo} == OPC_CLS) begin
                            n_draw = 1'b1;
                        end else if ({r_hi, r_lo} == OPC_RET) begin
                            n_sp = r_sp - 4'd1;
                            stk_re = 1'b1;
                            stk_a = r_sp - 4'd1;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    OP_JP: n_pc = nnn;
                    OP_CALL: begin
                        stk_we = 1'b1;
                        stk_wd = r_pc;
                        n_sp = r_sp + 4'd1;
                        n_pc = nnn;
                    end
                    OP_SE: if (r_vx == nn) n_pc = pc4;
                    OP_SNE: if (r_vx != nn) n_pc = pc4;
                    OP_SEV: begin
                        if (op_n != 4'd0) begin
                            n_bad = 1'b1;
                        end else if (r_vx == r_vy) begin
                            n_pc = pc4;
                        end
                    end
                    OP_SNEV: begin
                        if (op_n != 4'd0) begin
                            n_bad = 1'b1;
                        end else if (r_vx != r_vy) begin
                            n_pc = pc4;
                        end
                    end
                    OP_LD: begin
                        rf_we = 1'b1;
                        rf_wd = nn;
                    end
                    OP_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = r_vx + nn;
                    end
                    OP_ALU: begin
                        rf_we = 1'b1;
                        case (op_n)
                            ALU_MOV: rf_wd = r_vy;
                            ALU_OR:  rf_wd = r_vx | r_vy;
                            ALU_AND: rf_wd = r_vx & r_vy;
                            ALU_XOR: rf_wd = r_vx ^ r_vy;
                            ALU_ADD: begin
                                rf_wd = sum9[7:0];
                                n_flag = sum9[8];
                            end
                            ALU_SUB: begin
                                rf_wd = r_vx - r_vy;
                                n_flag = (r_vx >= r_vy);
                            end
                            ALU_SHR: begin
                                rf_wd = {1'b0, r_vx[7:1]};
                                n_flag = r_vx[0];
                            end
                            ALU_SBN: begin
                                rf_wd = r_vy - r_vx;
                                n_flag = (r_vy >= r_vx);
                            end
                            ALU_SHL: begin
                                rf_wd = {r_vx[6:0], 1'b0};
                                n_flag = r_vx[7];
                            end
                            default: begin
                                rf_we = 1'b0;
                                n_bad = 1'b1;
                            end
                        endcase
                    end
                    OP_LDI: n_i = nnn;
                    OP_JPV: n_pc = {4'd0, r_rf_q} + nnn;
                    OP_RND: begin
                        rf_we = 1'b1;
                        rf_wd = r_item.random_byte & nn;
                    end
                    OP_DRW: begin
                        n_flag = 1'b0;
                        n_draw = 1'b1;
                    end
                    OP_KEY: begin
                        if (nn == KEY_DOWN) begin
                            if (key_hit) n_pc = pc4;
                        end else if (nn == KEY_UP) begin
                            if (!key_hit) n_pc = pc4;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    default: begin
                        case (nn)
                            MISC_GDT: begin
                                rf_we = 1'b1;
                                rf_wd = r_dt;
                            end
                            MISC_WKEY: begin
                                if (r_item.keys_down == 16'd0) begin
                                    n_pc = r_pc;
                                    n_wait = 1'b1;
                                end else begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'd0, key_idx};
                                end
                            end
                            MISC_SDT: n_dt = r_vx;
                            MISC_SST: n_st = r_vx;
                            MISC_ADDI: begin
                                n_flag = sum13[12];
                                n_i = sum13[11:0];
                            end
                            MISC_FONT: n_i = {6'd0, r_vx[3:0], 2'b00} + {8'd0, r_vx[3:0]};
                            MISC_BCD, MISC_STR, MISC_LDR: ;
                            default: n_bad = 1'b1;
                        endcase
                    end
                endcase
            end
            U_RET: n_pc = r_stk_q + 12'd2;
            U_FCLR: begin
                fb_we = 1'b1;
                fb_a = i_cmd.cnt[4:0];
            end
            U_WR_VF: begin
                rf_we = 1'b1;
                rf_wa = 4'd15;
                rf_wd = {7'd0, r_flag};
            end
            U_DMRD: begin
                mem_re = 1'b1;
                mem_a = i_cnt;
            end
            U_DFRD: begin
                n_sprite = r_mem_q;
                fb_re = 1'b1;
            end
            U_DFWR: begin
                fb_we = 1'b1;
                fb_wd = r_fb_q ^ mask;
                n_flag = r_flag | (|(r_fb_q & mask));
            end
            U_BCD0: begin
                mem_we = 1'b1;
                mem_a = r_i;
                mem_wd = {6'd0, hund};
                n_tmp = rem100;
            end
            U_BCD1: begin
                mem_we = 1'b1;
                mem_a = r_i + 12'd1;
                mem_wd = {4'd0, tens};
                n_tmp = ones;
            end
            U_BCD2: begin
                mem_we = 1'b1;
                mem_a = r_i + 12'd2;
                mem_wd = {1'b0, r_tmp};
            end
            U_STRD: begin
                rf_re = 1'b1;
                rf_ra = cnt4;
            end
            U_STWR: begin
                mem_we = 1'b1;
                mem_a = i_cnt;
                mem_wd = r_rf_q;
            end
            U_LDRD: begin
                mem_re = 1'b1;
                mem_a = i_cnt;
            end
            U_LDWR: begin
                rf_we = 1'b1;
                rf_wa = cnt4;
                rf_wd = r_mem_q;
            end
            U_DONE: begin
                if (r_item.kind == KIND_EXEC) begin
                    if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                    if (r_st != 8'd0) n_st = r_st - 8'd1;
                end
                case (r_item.kind)
                    KIND_MEM_RD: n_out.read_data = r_mem_q;
                    KIND_PIX_RD: n_out.read_data =
                        {7'd0, r_fb_q[r_item.address[5:0]] & ~r_item.address[11]};
                    default:     n_out.read_data = 8'd0;
                endcase
                n_out.prog_counter_out = r_pc;
                n_out.draw_flag = r_draw;
                n_out.sound_on = (n_st != 8'd0);
                n_out.waiting_key = r_wait;
                n_out.bad_opcode = r_bad;
            end
            default: ;
        endcase
        if (i_cfg_we) begin
            n_start_pc = i_cfg_data;
            n_pc = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_a] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_wa] <= rf_wd;
        end
        if (rf_re) begin
            r_rf_q <= rf[rf_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk[stk_a] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_q <= stk[stk_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb[fb_a] <= fb_wd;
        end
        if (fb_re) begin
            r_fb_q <= fb[fb_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= PC_RESET;
            r_start_pc <= PC_RESET;
            r_i        <= 12'd0;
            r_sp       <= 4'd0;
            r_dt       <= 8'd0;
            r_st       <= 8'd0;
        end else begin
            r_pc       <= n_pc;
            r_start_pc <= n_start_pc;
            r_i        <= n_i;
            r_sp       <= n_sp;
            r_dt       <= n_dt;
            r_st       <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_out    <= n_out;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_flag   <= n_flag;
        r_draw   <= n_draw;
        r_wait   <= n_wait;
        r_bad    <= n_bad;
        r_sprite <= n_sprite;
        r_tmp    <= n_tmp;
    end

endmodule

>>> dv/tb_eight_bit_vm_instruction_core.sv
module tb_eight_bit_vm_instruction_core;
    import evm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int STEPS_PER_PHASE = 100;

    typedef struct packed {
        t_in_item  it;
        bit        typed;
        t_out_item ex;
    } t_row;

    localparam t_in_item NO_ITEM = '0;

    localparam t_row DIRECTED [25] = '{
        '{'{KIND_MEM_RD, 12'h000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'hF0, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_RD, 12'hFFF, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_PIX_RD, 12'h000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_PIX_RD, 12'h7FF, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_PIX_RD, 12'hFFF, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_WR, 12'hFFF, 8'hFF, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_RD, 12'hFFF, 8'h00, 16'hFFFF, 8'hFF}, 1'b1, '{8'hFF, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_WR, 12'h200, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_WR, 12'h201, 8'hE0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h200, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h202, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_WR, 12'h202, 8'hF0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h202, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_MEM_WR, 12'h203, 8'h0A, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h202, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h202, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'h8000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_WR, 12'h204, 8'h01, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_WR, 12'h205, 8'h23, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'h0000, 8'h00}, 1'b1, '{8'h00, 12'h206, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{KIND_MEM_WR, 12'h206, 8'hD0, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_WR, 12'h207, 8'h0F, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'hFFFF, 8'hFF}, 1'b0, '0},
        '{'{KIND_PIX_RD, 12'h3CF, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_WR, 12'h208, 8'h80, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_WR, 12'h209, 8'h0E, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_EXEC,   12'h000, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{KIND_MEM_RD, 12'h050, 8'h00, 16'h0000, 8'h00}, 1'b0, '0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [11:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;

    eight_bit_vm_instruction_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // machine state mirror
    logic [7:0]  vm_mem [4096];
    bit          vm_fb [2048];
    logic [7:0]  vm_v [16];
    logic [11:0] vm_stack [16];
    logic [3:0]  vm_sp;
    logic [11:0] vm_i;
    logic [11:0] vm_pc;
    logic [7:0]  vm_dt;
    logic [7:0]  vm_st;

    t_out_item   pending_results [$];
    int          errors;
    int          cycles;
    int          n_items;
    int          n_exec;
    int          n_draws;
    int          n_results;
    bit          quiet;
    int          out_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic vm_reset();
        for (int a = 0; a < 4096; a++) vm_mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
        for (int p = 0; p < 2048; p++) vm_fb[p] = 1'b0;
        for (int r = 0; r < 16; r++) begin
            vm_v[r] = 8'h00;
            vm_stack[r] = 12'h000;
        end
        vm_sp = '0;
        vm_i = '0;
        vm_pc = PC_RESET;
        vm_dt = '0;
        vm_st = '0;
    endtask

    task automatic vm_run(input logic [15:0] keys, input logic [7:0] rnd,
                          output bit draw, output bit waitk, output bit bad);
        logic [11:0] pc;
        logic [11:0] nxt;
        logic [15:0] op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  sum;
        logic [12:0] isum;
        logic [7:0]  line;
        int          x0;
        int          y0;
        int          yy;
        int          k;
        bit          hit;
        pc = vm_pc;
        op = {vm_mem[pc], vm_mem[pc + 12'd1]};
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        vx = vm_v[x];
        vy = vm_v[y];
        nxt = pc + 12'd2;
        draw = 0;
        waitk = 0;
        bad = 0;
        case (op[15:12])
            OP_SYS: begin
                if (op == OPC_CLS) begin
                    for (int p = 0; p < 2048; p++) vm_fb[p] = 1'b0;
                    draw = 1;
                end else if (op == OPC_RET) begin
                    vm_sp = vm_sp - 4'd1;
                    nxt = vm_stack[vm_sp] + 12'd2;
                end else begin
                    bad = 1;
                end
            end
            OP_JP: nxt = op[11:0];
            OP_CALL: begin
                vm_stack[vm_sp] = pc;
                vm_sp = vm_sp + 4'd1;
                nxt = op[11:0];
            end
            OP_SE: if (vx == nn) nxt = pc + 12'd4;
            OP_SNE: if (vx != nn) nxt = pc + 12'd4;
            OP_SEV: begin
                if (n != 0) bad = 1;
                else if (vx == vy) nxt = pc + 12'd4;
            end
            OP_LD: vm_v[x] = nn;
            OP_ADD: vm_v[x] = vx + nn;
            OP_ALU: begin
                case (n)
                    ALU_MOV: vm_v[x] = vy;
                    ALU_OR:  vm_v[x] = vx | vy;
                    ALU_AND: vm_v[x] = vx & vy;
                    ALU_XOR: vm_v[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vm_v[x] = sum[7:0];
                        vm_v[15] = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        vm_v[x] = vx - vy;
                        vm_v[15] = {7'd0, vx >= vy};
                    end
                    ALU_SHR: begin
                        vm_v[x] = vx >> 1;
                        vm_v[15] = {7'd0, vx[0]};
                    end
                    ALU_SBN: begin
                        vm_v[x] = vy - vx;
                        vm_v[15] = {7'd0, vy >= vx};
                    end
                    ALU_SHL: begin
                        vm_v[x] = vx << 1;
                        vm_v[15] = {7'd0, vx[7]};
                    end
                    default: bad = 1;
                endcase
            end
            OP_SNEV: begin
                if (n != 0) bad = 1;
                else if (vx != vy) nxt = pc + 12'd4;
            end
            OP_LDI: vm_i = op[11:0];
            OP_JPV: nxt = {4'd0, vm_v[0]} + op[11:0];
            OP_RND: vm_v[x] = rnd & nn;
            OP_DRW: begin
                hit = 0;
                x0 = vx % 64;
                y0 = vy % 32;
                for (int r = 0; r < n; r++) begin
                    line = vm_mem[vm_i + 12'(r)];
                    yy = (y0 + r) % 32;
                    for (int c = 0; c < 8; c++) begin
                        if (line[7 - c]) begin
                            k = yy * 64 + (x0 + c) % 64;
                            if (vm_fb[k]) hit = 1;
                            vm_fb[k] = ~vm_fb[k];
                        end
                    end
                end
                vm_v[15] = {7'd0, hit};
                draw = 1;
            end
            OP_KEY: begin
                if (nn == KEY_DOWN) begin
                    if (keys[vx[3:0]]) nxt = pc + 12'd4;
                end else if (nn == KEY_UP) begin
                    if (!keys[vx[3:0]]) nxt = pc + 12'd4;
                end else begin
                    bad = 1;
                end
            end
            default: begin
                case (nn)
                    MISC_GDT: vm_v[x] = vm_dt;
                    MISC_WKEY: begin
                        if (keys == 16'h0000) begin
                            nxt = pc;
                            waitk = 1;
                        end else begin
                            k = 0;
                            while (!keys[k]) k++;
                            vm_v[x] = 8'(k);
                        end
                    end
                    MISC_SDT: vm_dt = vx;
                    MISC_SST: vm_st = vx;
                    MISC_ADDI: begin
                        isum = {1'b0, vm_i} + {5'd0, vx};
                        vm_v[15] = {7'd0, isum[12]};
                        vm_i = isum[11:0];
                    end
                    MISC_FONT: vm_i = 12'd5 * {8'd0, vx[3:0]};
                    MISC_BCD: begin
                        vm_mem[vm_i] = 8'(vx / 100);
                        vm_mem[vm_i + 12'd1] = 8'((vx / 10) % 10);
                        vm_mem[vm_i + 12'd2] = 8'(vx % 10);
                    end
                    MISC_STR: for (int r = 0; r <= x; r++) vm_mem[vm_i + 12'(r)] = vm_v[r];
                    MISC_LDR: for (int r = 0; r <= x; r++) vm_v[r] = vm_mem[vm_i + 12'(r)];
                    default: bad = 1;
                endcase
            end
        endcase
        if (vm_dt != 0) vm_dt = vm_dt - 8'd1;
        if (vm_st != 0) vm_st = vm_st - 8'd1;
        vm_pc = nxt;
    endtask

    task automatic vm_item(input t_in_item it, output t_out_item res);
        bit draw;
        bit waitk;
        bit bad;
        res = '0;
        draw = 0;
        waitk = 0;
        bad = 0;
        case (it.kind)
            KIND_MEM_WR: vm_mem[it.address] = it.data;
            KIND_EXEC: vm_run(it.keys_down, it.random_byte, draw, waitk, bad);
            KIND_PIX_RD: res.read_data = (it.address < 12'd2048) ? {7'd0, vm_fb[it.address]} : 8'd0;
            default: res.read_data = vm_mem[it.address];
        endcase
        res.prog_counter_out = vm_pc;
        res.draw_flag = draw;
        res.sound_on = (vm_st != 0);
        res.waiting_key = waitk;
        res.bad_opcode = bad;
    endtask

    task automatic send(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        int gap;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        vm_item(it, res);
        pending_results.push_back(typed ? typed_res : res);
        n_items++;
        if (it.kind == KIND_EXEC) n_exec++;
        if (res.draw_flag) n_draws++;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_start(input logic [11:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vm_pc = v;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_opcode();
        logic [15:0] op;
        logic [7:0]  misc [9];
        misc = '{MISC_GDT, MISC_WKEY, MISC_SDT, MISC_SST, MISC_ADDI,
                 MISC_FONT, MISC_BCD, MISC_STR, MISC_LDR};
        op = 16'($urandom);
        case (op[15:12])
            OP_SYS: begin
                case ($urandom_range(0, 3))
                    0: op = OPC_CLS;
                    1: op = OPC_RET;
                    default: ;
                endcase
            end
            OP_SEV, OP_SNEV: if ($urandom_range(0, 4) != 0) op[3:0] = 4'h0;
            OP_ALU: begin
                if ($urandom_range(0, 7) != 0) begin
                    op[3:0] = ($urandom_range(0, 8) == 8) ? ALU_SHL : 4'($urandom_range(0, 7));
                end
            end
            OP_DRW: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
            OP_KEY: if ($urandom_range(0, 5) != 0) op[7:0] = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
            OP_MISC: if ($urandom_range(0, 7) != 0) op[7:0] = misc[$urandom_range(0, 8)];
            default: ;
        endcase
        return op;
    endfunction

    task automatic random_step();
        t_in_item it;
        logic [15:0] op;
        it = '0;
        it.keys_down = rand_keys();
        it.random_byte = 8'($urandom);
        case ($urandom_range(0, 9))
            7: begin
                it.kind = KIND_PIX_RD;
                it.address = $urandom_range(0, 3) != 0 ? 12'($urandom_range(0, 2047)) : 12'($urandom);
                send(it, 1'b0, '0);
            end
            8: begin
                it.kind = KIND_MEM_RD;
                it.address = 12'($urandom);
                send(it, 1'b0, '0);
            end
            9: begin
                it.kind = KIND_MEM_WR;
                it.address = 12'($urandom);
                it.data = 8'($urandom);
                send(it, 1'b0, '0);
            end
            default: begin
                op = rand_opcode();
                it.kind = KIND_MEM_WR;
                it.address = vm_pc;
                it.data = op[15:8];
                send(it, 1'b0, '0);
                it.address = vm_pc + 12'd1;
                it.data = op[7:0];
                send(it, 1'b0, '0);
                it.kind = KIND_EXEC;
                it.address = 12'($urandom);
                it.data = 8'($urandom);
                send(it, 1'b0, '0);
            end
        endcase
    endtask

    // result receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold <= 0;
        end else if (o_out_valid && i_out_ready) begin
            out_hold <= quiet ? 0 : $urandom_range(0, 18);
            i_out_ready <= quiet;
        end else if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction %h", $time, o_out_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.read_data !== want.read_data) begin
                    $display("%0t read_data exp %h got %h", $time, want.read_data,
                             o_out_item.read_data);
                    errors++;
                end
                if (o_out_item.prog_counter_out !== want.prog_counter_out) begin
                    $display("%0t prog_counter_out exp %h got %h", $time,
                             want.prog_counter_out, o_out_item.prog_counter_out);
                    errors++;
                end
                if (o_out_item.draw_flag !== want.draw_flag) begin
                    $display("%0t draw_flag exp %b got %b", $time, want.draw_flag,
                             o_out_item.draw_flag);
                    errors++;
                end
                if (o_out_item.sound_on !== want.sound_on) begin
                    $display("%0t sound_on exp %b got %b", $time, want.sound_on,
                             o_out_item.sound_on);
                    errors++;
                end
                if (o_out_item.waiting_key !== want.waiting_key) begin
                    $display("%0t waiting_key exp %b got %b", $time, want.waiting_key,
                             o_out_item.waiting_key);
                    errors++;
                end
                if (o_out_item.bad_opcode !== want.bad_opcode) begin
                    $display("%0t bad_opcode exp %b got %b", $time, want.bad_opcode,
                             o_out_item.bad_opcode);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [11:0] starts [6];
        errors = 0;
        cycles = 0;
        n_items = 0;
        n_exec = 0;
        n_draws = 0;
        n_results = 0;
        quiet = 0;
        starts = '{12'h000, 12'hFFF, 12'hFFE, 12'($urandom), 12'h200, 12'($urandom)};
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= NO_ITEM;
        vm_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing pass
        do @(posedge i_clk); while (!o_in_ready);

        for (int r = 0; r < 25; r++) send(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].ex);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            load_start(starts[ph]);
            for (int s = 0; s < STEPS_PER_PHASE; s++) begin
                if (s % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
                random_step();
            end
            quiet = 0;
        end

        drain();
        $display("%0d transactions sent, %0d instructions executed, %0d screen updates",
                 n_items, n_exec, n_draws);
        $display("%0d results checked across 7 start addresses", n_results);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/evm_pkg.sv
rtl/core/evm_ctrl.sv
rtl/core/evm_dp.sv
rtl/core/eight_bit_vm_instruction_core.sv
dv/tb_eight_bit_vm_instruction_core.sv
